[src/button_click_gesture_classifier_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture classifier
// Clocked property shorthands with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_GESTURE_CLASSIFIER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BCGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BCGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bcgc_pkg.sv]
// ----------------------------------------------------------------------------
// bcgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bcgc_pkg;

	localparam int unsigned THRESH_WIDTH = 16;
	localparam int unsigned EVENT_WIDTH  = 3;
	localparam int unsigned CFG_IDX_W    = 2;

	typedef logic [THRESH_WIDTH-1:0] thresh_t;

	typedef enum logic [EVENT_WIDTH-1:0] {
		EV_NONE   = 3'd0,
		EV_DOWN   = 3'd1,
		EV_LONG   = 3'd2,
		EV_VLONG  = 3'd3,
		EV_SINGLE = 3'd4,
		EV_DOUBLE = 3'd5,
		EV_TRIPLE = 3'd6
	} gesture_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_PRESS      = 2'd0,
		REG_VERY_LONG_PRESS = 2'd1,
		REG_CLICK_GAP       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		thresh_t long_press_ticks;
		thresh_t very_long_press_ticks;
		thresh_t click_gap_ticks;
	} cfg_t;

	localparam thresh_t LONG_PRESS_RESET      = 16'd60;
	localparam thresh_t VERY_LONG_PRESS_RESET = 16'd180;
	localparam thresh_t CLICK_GAP_RESET       = 16'd50;

	localparam logic [1:0] TALLY_MAX = 2'd3;

endpackage

[src/bcgc_in_if.sv]
// ----------------------------------------------------------------------------
// bcgc_in_if
// Input channel: one sampled button level per transaction.
// ----------------------------------------------------------------------------
interface bcgc_in_if;
	logic valid;
	logic ready;
	logic button_pressed;

	modport source (output valid, output button_pressed, input ready);
	modport sink (input valid, input button_pressed, output ready);
endinterface

[src/bcgc_out_if.sv]
// ----------------------------------------------------------------------------
// bcgc_out_if
// Output channel: one gesture event per transaction.
// ----------------------------------------------------------------------------
interface bcgc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] gesture_event;

	modport source (output valid, output gesture_event, input ready);
	modport sink (input valid, input gesture_event, output ready);
endinterface

[src/bcgc_step.sv]
// ----------------------------------------------------------------------------
// bcgc_step
// Next-state and event logic for one button tick.
// ----------------------------------------------------------------------------
module bcgc_step #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                   pressed,
	input  bcgc_pkg::cfg_t         cfg,
	input  logic [COUNT_WIDTH-1:0] hold_cur,
	input  logic [COUNT_WIDTH-1:0] release_cur,
	input  logic [1:0]             tally_cur,
	output logic [COUNT_WIDTH-1:0] hold_nxt,
	output logic [COUNT_WIDTH-1:0] release_nxt,
	output logic [1:0]             tally_nxt,
	output bcgc_pkg::gesture_t     gesture
);
	import bcgc_pkg::*;

	localparam int unsigned CW = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

	logic                   hold_sat;
	logic                   rel_adv;
	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [COUNT_WIDTH-1:0] rel_new;
	logic [CW-1:0]          hold_inc_x;
	logic [CW-1:0]          hold_cur_x;
	logic [CW-1:0]          rel_new_x;
	logic [CW-1:0]          long_x;
	logic [CW-1:0]          vlong_x;
	logic [CW-1:0]          gap_x;
	logic                   is_click;
	logic [1:0]             tally_cnt;

	assign hold_sat   = (hold_cur == {COUNT_WIDTH{1'b1}});
	assign rel_adv    = (release_cur != {COUNT_WIDTH{1'b1}});
	assign hold_inc   = hold_cur + COUNT_WIDTH'(1);
	assign rel_new    = rel_adv ? release_cur + COUNT_WIDTH'(1) : release_cur;
	assign hold_inc_x = CW'(hold_inc);
	assign hold_cur_x = CW'(hold_cur);
	assign rel_new_x  = CW'(rel_new);
	assign long_x     = CW'(cfg.long_press_ticks);
	assign vlong_x    = CW'(cfg.very_long_press_ticks);
	assign gap_x      = CW'(cfg.click_gap_ticks);
	assign is_click   = (hold_cur != '0) && (hold_cur_x < long_x);
	assign tally_cnt  = (is_click && tally_cur != TALLY_MAX) ? tally_cur + 2'd1 : tally_cur;

	always_comb begin
		gesture     = EV_NONE;
		hold_nxt    = '0;
		release_nxt = '0;
		tally_nxt   = tally_cur;
		if (pressed) begin
			hold_nxt = hold_sat ? hold_cur : hold_inc;
			if (!hold_sat) begin
				if (hold_inc == COUNT_WIDTH'(1)) begin
					gesture = EV_DOWN;
				end else if (hold_inc_x == long_x) begin
					gesture = EV_LONG;
				end else if (hold_inc_x == vlong_x) begin
					gesture = EV_VLONG;
				end
			end
		end else begin
			release_nxt = rel_new;
			tally_nxt   = tally_cnt;
			if (rel_adv && rel_new_x == gap_x) begin
				tally_nxt = 2'd0;
				case (tally_cnt)
					2'd1:    gesture = EV_SINGLE;
					2'd2:    gesture = EV_DOUBLE;
					2'd3:    gesture = EV_TRIPLE;
					default: gesture = EV_NONE;
				endcase
			end
		end
	end

endmodule

[src/button_click_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// button_click_gesture_classifier
// Classifies sampled push-button levels into press, long-press and click events.
//
//   channel   dir   payload              width
//   in_ch     in    button_pressed       1
//   out_ch    out   gesture_event        3
//   cfg_*     in    thresholds by index  16
//
// One tick per cycle sustained while the output is not stalled; each tick passes
// through the input register and the result register around the step logic.
// Reset loads the default thresholds, clears hold count and tally, and
// saturates the release count. A stalled output holds its event while the
// input register still accepts one more tick.
// ----------------------------------------------------------------------------
`include "button_click_gesture_classifier_macros.svh"

module button_click_gesture_classifier #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  bcgc_pkg::thresh_t       cfg_data,
	bcgc_in_if.sink                 in_ch,
	bcgc_out_if.source              out_ch
);
	import bcgc_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic                   pressed_s1;
	logic                   valid_s2;
	gesture_t               gesture_s2;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [COUNT_WIDTH-1:0] release_q;
	logic [1:0]             tally_q;
	logic [COUNT_WIDTH-1:0] hold_d;
	logic [COUNT_WIDTH-1:0] release_d;
	logic [1:0]             tally_d;
	gesture_t               gesture_d;
	logic                   adv_s2;
	logic                   fire_s1;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign fire_s1     = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks      <= LONG_PRESS_RESET;
			cfg_q.very_long_press_ticks <= VERY_LONG_PRESS_RESET;
			cfg_q.click_gap_ticks       <= CLICK_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_PRESS:      cfg_q.long_press_ticks      <= cfg_data;
				REG_VERY_LONG_PRESS: cfg_q.very_long_press_ticks <= cfg_data;
				REG_CLICK_GAP:       cfg_q.click_gap_ticks       <= cfg_data;
				default:             cfg_q                       <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			pressed_s1 <= in_ch.button_pressed;
		end
	end

	bcgc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.pressed     (pressed_s1),
		.cfg         (cfg_q),
		.hold_cur    (hold_q),
		.release_cur (release_q),
		.tally_cur   (tally_q),
		.hold_nxt    (hold_d),
		.release_nxt (release_d),
		.tally_nxt   (tally_d),
		.gesture     (gesture_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			release_q <= {COUNT_WIDTH{1'b1}};
			tally_q   <= 2'd0;
		end else if (fire_s1) begin
			hold_q    <= hold_d;
			release_q <= release_d;
			tally_q   <= tally_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			gesture_s2 <= gesture_d;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.gesture_event = gesture_s2;

	`BCGC_ASSERT_NOW(a_hold_clears_release, clk, arst_n, hold_q != '0, release_q == '0, "release count nonzero while held")
	`BCGC_ASSERT_NEXT(a_down_starts_hold, clk, arst_n, fire_s1 && gesture_d == EV_DOWN, hold_q == COUNT_WIDTH'(1), "press down without hold count of one")
	`BCGC_ASSERT_NEXT(a_drain_empties, clk, arst_n, valid_s2 && out_ch.ready && !valid_s1, !valid_s2, "result repeated after drain")
	`BCGC_ASSERT_NOW(a_press_no_click_event, clk, arst_n, fire_s1 && pressed_s1, gesture_d != EV_SINGLE && gesture_d != EV_DOUBLE && gesture_d != EV_TRIPLE, "click event on held tick")

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button gesture classifier. A directed table
// covers start-up, each gesture, tally and counter saturation, coinciding and
// extreme thresholds. Random click bursts, long holds and noise follow under
// several threshold settings and handshake idling modes. Every gesture_event
// transaction is compared in order with a typed row's event or a cycle-free model.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcgc_pkg::*;

	localparam int unsigned COUNT_W       = 16;
	localparam int unsigned RANDOM_TICKS  = 1000;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned SEG_CAP       = 120;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam longint unsigned CYCLE_LIMIT = 2000000;
	localparam thresh_t THRESH_MIN = 16'd1;
	localparam thresh_t THRESH_TOP = 16'hFFFE;

	typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		thresh_t     value;
		logic        level;
		int unsigned count;
		bit          typed;
		gesture_t    ev;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic [1:0] cfg_index;
	thresh_t cfg_data;

	bcgc_in_if  in_ch ();
	bcgc_out_if out_ch ();

	button_click_gesture_classifier #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	cfg_t               thresholds;
	logic [COUNT_W-1:0] hold_count;
	logic [COUNT_W-1:0] release_count;
	logic [1:0]         click_count;
	gesture_t           expected_events [$];
	stim_row_t          directed_rows [$];

	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned ticks_sent;
	int unsigned writes_done;
	int unsigned err_cnt;
	int unsigned event_hits [8];
	longint unsigned cycle_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function void reset_predictor();
		thresholds.long_press_ticks      = LONG_PRESS_RESET;
		thresholds.very_long_press_ticks = VERY_LONG_PRESS_RESET;
		thresholds.click_gap_ticks       = CLICK_GAP_RESET;
		hold_count    = '0;
		release_count = '1;
		click_count   = '0;
	endfunction

	function gesture_t classify_tick(input logic pressed);
		gesture_t ev;
		logic     advanced;
		ev       = EV_NONE;
		advanced = 1'b0;
		if (pressed) begin
			if (hold_count != '1) begin
				hold_count = hold_count + 1'b1;
				if (hold_count == 1) begin
					ev = EV_DOWN;
				end else if (hold_count == thresholds.long_press_ticks) begin
					ev = EV_LONG;
				end else if (hold_count == thresholds.very_long_press_ticks) begin
					ev = EV_VLONG;
				end
			end
			release_count = '0;
		end else begin
			if (release_count != '1) begin
				release_count = release_count + 1'b1;
				advanced      = 1'b1;
			end
			if (hold_count != 0 && hold_count < thresholds.long_press_ticks &&
			    click_count != TALLY_MAX) begin
				click_count = click_count + 1'b1;
			end
			if (advanced && release_count == thresholds.click_gap_ticks) begin
				case (click_count)
					2'd1: ev = EV_SINGLE;
					2'd2: ev = EV_DOUBLE;
					2'd3: ev = EV_TRIPLE;
					default: ev = EV_NONE;
				endcase
				click_count = '0;
			end
			hold_count = '0;
		end
		return ev;
	endfunction

	function void add_run(input logic level, input int unsigned count, input bit typed,
	                      input gesture_t ev);
		stim_row_t row;
		row.kind  = ROW_TICKS;
		row.idx   = REG_LONG_PRESS;
		row.value = '0;
		row.level = level;
		row.count = count;
		row.typed = typed;
		row.ev    = ev;
		directed_rows.push_back(row);
	endfunction

	function void add_write(input reg_idx_t idx, input thresh_t value);
		stim_row_t row;
		row.kind  = ROW_WRITE;
		row.idx   = idx;
		row.value = value;
		row.level = 1'b0;
		row.count = 0;
		row.typed = 1'b0;
		row.ev    = EV_NONE;
		directed_rows.push_back(row);
	endfunction

	function automatic int unsigned capped(input int unsigned ticks);
		return (ticks > SEG_CAP) ? SEG_CAP : ticks;
	endfunction

	function automatic thresh_t pick_threshold();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0)
			return THRESH_MIN;
		if (r == 1)
			return THRESH_TOP;
		return thresh_t'($urandom_range(2, 24));
	endfunction

	task send_tick(input logic level, input bit typed, input gesture_t typed_ev);
		gesture_t ev;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.button_pressed <= level;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		ev = classify_tick(level);
		expected_events.push_back(typed ? typed_ev : ev);
		ticks_sent++;
	endtask

	task send_run(input logic level, input int unsigned count, input bit typed,
	              input gesture_t ev);
		for (int unsigned i = 0; i < count; i++)
			send_tick(level, typed && (i == count - 1), ev);
	endtask

	task drain_block();
		in_ch.valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_threshold(input reg_idx_t idx, input thresh_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LONG_PRESS:      thresholds.long_press_ticks      = value;
			REG_VERY_LONG_PRESS: thresholds.very_long_press_ticks = value;
			REG_CLICK_GAP:       thresholds.click_gap_ticks       = value;
			default: ;
		endcase
		writes_done++;
	endtask

	task run_random(input int unsigned target);
		int unsigned start;
		int unsigned r;
		int unsigned clicks;
		int unsigned len;
		start = ticks_sent;
		while (ticks_sent - start < target) begin
			r = $urandom_range(99);
			if (r < 15) begin
				send_run(1'($urandom_range(1)), $urandom_range(1, 4), 1'b0, EV_NONE);
			end else if (r < 35) begin
				len = (r < 25) ? thresholds.long_press_ticks : thresholds.very_long_press_ticks;
				send_run(1'b1, capped(len) + $urandom_range(0, 2), 1'b0, EV_NONE);
				send_run(1'b0, capped(thresholds.click_gap_ticks + $urandom_range(0, 2)),
				         1'b0, EV_NONE);
			end else begin
				clicks = $urandom_range(1, 5);
				for (int unsigned k = 1; k <= clicks; k++) begin
					len = (thresholds.long_press_ticks > 1) ?
					      $urandom_range(1, capped(thresholds.long_press_ticks - 1)) : 1;
					send_run(1'b1, len, 1'b0, EV_NONE);
					if (k < clicks) begin
						len = (thresholds.click_gap_ticks > 1) ?
						      $urandom_range(1, capped(thresholds.click_gap_ticks - 1)) : 1;
						send_run(1'b0, len, 1'b0, EV_NONE);
					end
				end
				if (r < 90)
					len = capped(thresholds.click_gap_ticks) + $urandom_range(0, 3);
				else
					len = $urandom_range(1, capped(thresholds.click_gap_ticks));
				send_run(1'b0, len, 1'b0, EV_NONE);
			end
		end
	endtask

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_events.size() == 0) begin
				$error("gesture_event: expected none pending, actual %0d", out_ch.gesture_event);
				err_cnt++;
			end else begin
				if (out_ch.gesture_event !== expected_events[0]) begin
					$error("gesture_event mismatch: expected %0d, actual %0d",
					       expected_events[0], out_ch.gesture_event);
					err_cnt++;
				end
				event_hits[out_ch.gesture_event]++;
				void'(expected_events.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_LONG_PRESS;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.button_pressed = 1'b0;
		out_ch.ready         = 1'b0;
		src_idle_pct         = 0;
		sink_stall_pct       = 0;
		ticks_sent           = 0;
		writes_done          = 0;
		err_cnt              = 0;
		cycle_cnt            = 0;
		foreach (event_hits[i])
			event_hits[i] = 0;
		reset_predictor();

		add_run(1'b0, 4, 1'b1, EV_NONE);
		add_run(1'b1, 1, 1'b1, EV_DOWN);
		add_run(1'b0, 50, 1'b1, EV_SINGLE);
		add_run(1'b1, 3, 1'b0, EV_NONE);
		add_run(1'b0, 2, 1'b0, EV_NONE);
		add_run(1'b1, 1, 1'b1, EV_DOWN);
		add_run(1'b0, 50, 1'b1, EV_DOUBLE);
		for (int i = 0; i < 3; i++) begin
			add_run(1'b1, 1, 1'b0, EV_NONE);
			add_run(1'b0, 1, 1'b0, EV_NONE);
		end
		add_run(1'b1, 1, 1'b0, EV_NONE);
		add_run(1'b0, 50, 1'b1, EV_TRIPLE);
		add_run(1'b1, 60, 1'b1, EV_LONG);
		add_run(1'b1, 120, 1'b1, EV_VLONG);
		add_run(1'b0, 50, 1'b1, EV_NONE);
		add_run(1'b1, 59, 1'b0, EV_NONE);
		add_run(1'b0, 50, 1'b1, EV_SINGLE);
		add_write(REG_LONG_PRESS, 16'd2);
		add_write(REG_VERY_LONG_PRESS, 16'd2);
		add_write(REG_CLICK_GAP, THRESH_MIN);
		add_run(1'b1, 2, 1'b1, EV_LONG);
		add_run(1'b0, 1, 1'b1, EV_NONE);
		add_write(REG_LONG_PRESS, THRESH_MIN);
		add_write(REG_VERY_LONG_PRESS, THRESH_MIN);
		add_run(1'b1, 1, 1'b1, EV_DOWN);
		add_run(1'b0, 1, 1'b1, EV_NONE);
		add_write(REG_LONG_PRESS, THRESH_TOP);
		add_write(REG_VERY_LONG_PRESS, THRESH_TOP);
		add_write(REG_CLICK_GAP, THRESH_TOP);
		add_run(1'b1, 1, 1'b1, EV_DOWN);
		add_run(1'b1, 40, 1'b1, EV_NONE);
		add_run(1'b0, 40, 1'b1, EV_NONE);
		add_write(REG_LONG_PRESS, 16'd3);
		add_write(REG_CLICK_GAP, THRESH_MIN);
		add_run(1'b1, 1, 1'b1, EV_DOWN);
		add_run(1'b0, 1, 1'b1, EV_DOUBLE);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				drain_block();
				write_threshold(row.idx, row.value);
			end else begin
				send_run(row.level, row.count, row.typed, row.ev);
			end
		end

		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_block();
			case (phase % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 78;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 78;
				end
				default: begin
					src_idle_pct   = 24;
					sink_stall_pct = 24;
				end
			endcase
			if (phase == 0) begin
				write_threshold(REG_LONG_PRESS, 16'd6);
				write_threshold(REG_VERY_LONG_PRESS, 16'd14);
				write_threshold(REG_CLICK_GAP, 16'd5);
			end else begin
				write_threshold(REG_LONG_PRESS, pick_threshold());
				write_threshold(REG_VERY_LONG_PRESS, pick_threshold());
				write_threshold(REG_CLICK_GAP, pick_threshold());
			end
			run_random(RANDOM_TICKS / RANDOM_PHASES);
		end

		drain_block();
		repeat (10) @(posedge clk);

		$display("Covered %0d button ticks over %0d threshold writes and four idling modes.",
		         ticks_sent, writes_done);
		$display("Events seen: down %0d, long %0d, very long %0d, single %0d, double %0d, triple %0d",
		         event_hits[EV_DOWN], event_hits[EV_LONG], event_hits[EV_VLONG],
		         event_hits[EV_SINGLE], event_hits[EV_DOUBLE], event_hits[EV_TRIPLE]);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
